### hw/rtl/fmd_pkg.sv
// Shared types, widths, register codes and defaults for the frame difference motion detector.
// Used by the channel interfaces and every RTL module of the block; depends on nothing.
`default_nettype none

package fmd_pkg;

    localparam int PIXEL_W    = 16;
    localparam int LUMA_W     = 7;
    localparam int THR_W      = 7;
    localparam int MINC_W     = 6;
    localparam int SHIFT_W    = 4;
    localparam int COUNT_W    = 6;
    localparam int FRAME_W    = 16;
    localparam int RCOUNT_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int DEF_NUM_SAMPLES = 48;

    localparam logic [COUNT_W-1:0] TALLY_MAX = 6'd63;

    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANGED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_SHIFT  = 2'd2;

    localparam logic [THR_W-1:0]   RST_DIFF_THRESHOLD = 7'd12;
    localparam logic [MINC_W-1:0]  RST_MIN_CHANGED    = 6'd4;
    localparam logic [SHIFT_W-1:0] RST_REFRESH_SHIFT  = 4'd5;

    typedef struct packed {
        logic [THR_W-1:0]   diff_threshold;
        logic [MINC_W-1:0]  min_changed;
        logic [SHIFT_W-1:0] refresh_shift;
    } t_cfg;

    typedef struct packed {
        logic [LUMA_W-1:0]   luma;
        logic                last;
        logic                loading;
        logic                refresh;
        logic [RCOUNT_W-1:0] refresh_count;
    } t_item;

    typedef struct packed {
        logic                movement;
        logic [COUNT_W-1:0]  changed_count;
        logic                refreshed;
        logic [RCOUNT_W-1:0] refresh_count;
    } t_result;

    function automatic logic [LUMA_W-1:0] luma_of(input logic [PIXEL_W-1:0] px);
        luma_of = {2'b00, px[15:11]} + {1'b0, px[10:5]} + {2'b00, px[4:0]};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fmd_pixel_if.sv
// Input channel of the motion detector: one RGB565 pixel word per handshake.
// Depends on fmd_pkg for the pixel width.
`default_nettype none

interface fmd_pixel_if import fmd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

### hw/rtl/fmd_result_if.sv
// Result channel of the motion detector: one frame summary word per handshake.
// Depends on fmd_pkg for the field widths.
`default_nettype none

interface fmd_result_if import fmd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                movement;
    logic [COUNT_W-1:0]  changed_count;
    logic                refreshed;
    logic [RCOUNT_W-1:0] refresh_count;

    modport source (output valid, output movement, output changed_count,
                    output refreshed, output refresh_count, input ready);
    modport sink (input valid, input movement, input changed_count,
                  input refreshed, input refresh_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/fmd_bg_store.sv
// Background brightness store: one entry per sample position, registered read.
// A write and a read of the same entry in one cycle returns the new data. Uses fmd_pkg.
`default_nettype none

module fmd_bg_store import fmd_pkg::*; #(
    parameter int NUM_SAMPLES = DEF_NUM_SAMPLES,
    localparam int POS_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rd_en,
    input  wire logic [POS_W-1:0]  i_rd_addr,
    input  wire logic              i_wr_en,
    input  wire logic [POS_W-1:0]  i_wr_addr,
    input  wire logic [LUMA_W-1:0] i_wr_data,
    output logic      [LUMA_W-1:0] o_rd_data
);

    logic [LUMA_W-1:0] r_mem [NUM_SAMPLES];
    logic [LUMA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/fmd_sequencer.sv
// Input stage: sample position, frame number and loading state, and the registered item word.
// Uses fmd_pkg; feeds the background store read address and the evaluation stage.
`default_nettype none

module fmd_sequencer import fmd_pkg::*; #(
    parameter int NUM_SAMPLES = DEF_NUM_SAMPLES,
    localparam int POS_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [PIXEL_W-1:0] i_pixel,
    input  wire logic [SHIFT_W-1:0] i_refresh_shift,
    input  wire logic               i_advance,
    output logic      [POS_W-1:0]   o_rd_pos,
    output logic                    o_s1_valid,
    output t_item                   o_s1_item,
    output logic      [POS_W-1:0]   o_s1_pos
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_SAMPLES - 1);

    logic [POS_W-1:0]   r_pos;
    logic               r_loaded;
    logic [FRAME_W-1:0] r_frame;
    logic               r_s1_valid;
    t_item              r_s1_item;
    logic [POS_W-1:0]   r_s1_pos;

    logic               is_last;
    logic [FRAME_W-1:0] frame_mask;
    t_item              n_item;

    always_comb begin
        is_last = (r_pos == LAST_POS);
        frame_mask = (FRAME_W'(1) << i_refresh_shift) - FRAME_W'(1);
        n_item.luma = luma_of(i_pixel);
        n_item.last = is_last;
        n_item.loading = !r_loaded;
        n_item.refresh = (r_frame != '0) && ((r_frame & frame_mask) == '0);
        n_item.refresh_count = RCOUNT_W'(r_frame >> i_refresh_shift);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_loaded <= 1'b0;
            r_frame <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_pos <= is_last ? '0 : r_pos + 1'b1;
                if (is_last) begin
                    if (r_loaded) begin
                        r_frame <= r_frame + 1'b1;
                    end
                    r_loaded <= 1'b1;
                end
                r_s1_valid <= 1'b1;
            end else if (i_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_item <= n_item;
            r_s1_pos <= r_pos;
        end
    end

    assign o_rd_pos = r_pos;
    assign o_s1_valid = r_s1_valid;
    assign o_s1_item = r_s1_item;
    assign o_s1_pos = r_s1_pos;

`ifndef SYNTHESIS
    a_loaded_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded |=> r_loaded)
        else $error("Background loaded flag cleared without reset.");

    a_frame_steps_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_accept && is_last) |=> $stable(r_frame))
        else $error("Frame number changed away from the end of a frame.");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !i_advance) |=> (r_s1_valid && $stable(r_s1_pos)))
        else $error("Input stage lost a word that was not passed on.");
`endif

endmodule

`default_nettype wire

### hw/rtl/fmd_evaluate.sv
// Evaluation stage: brightness difference, changed tally, background write and result registers.
// Uses fmd_pkg; takes the item word from fmd_sequencer and the entry from fmd_bg_store.
`default_nettype none

module fmd_evaluate import fmd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_s1_valid,
    input  wire t_item             i_s1_item,
    input  wire logic [LUMA_W-1:0] i_bg_level,
    input  wire logic              i_out_ready,
    output logic                   o_stall,
    output logic                   o_advance,
    output logic                   o_wr_en,
    output logic      [LUMA_W-1:0] o_wr_data,
    output logic                   o_out_valid,
    output t_result                o_result
);

    logic [COUNT_W-1:0] r_tally;
    logic               r_out_valid;
    t_result            r_result;
    logic               r_skid_valid;
    t_result            r_skid;

    logic [LUMA_W-1:0]  diff;
    logic               changed;
    logic [COUNT_W-1:0] n_tally;
    logic               produce;
    logic               pop;
    t_result            n_result;

    always_comb begin
        diff = (i_s1_item.luma >= i_bg_level) ? i_s1_item.luma - i_bg_level
                                              : i_bg_level - i_s1_item.luma;
        changed = diff > i_cfg.diff_threshold;
        n_tally = (changed && (r_tally != TALLY_MAX)) ? r_tally + 1'b1 : r_tally;
        pop = r_out_valid && i_out_ready;
        o_stall = i_s1_valid && i_s1_item.last && !i_s1_item.loading && r_skid_valid;
        o_advance = i_s1_valid && !o_stall;
        produce = o_advance && i_s1_item.last && !i_s1_item.loading;
        o_wr_en = o_advance && (i_s1_item.loading || i_s1_item.refresh);
        o_wr_data = i_s1_item.luma;
        n_result.movement = n_tally >= i_cfg.min_changed;
        n_result.changed_count = n_tally;
        n_result.refreshed = i_s1_item.refresh;
        n_result.refresh_count = i_s1_item.refresh_count;
    end

    // A second result register takes a word that arrives while the first is still waiting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (o_advance && !i_s1_item.loading) begin
                r_tally <= i_s1_item.last ? '0 : n_tally;
            end
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (produce && r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (pop && !r_skid_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_result <= r_skid;
            end
        end else if (produce) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid <= n_result;
            end else begin
                r_result <= n_result;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

### hw/rtl/frame_difference_motion_detector.sv
// Motion detector by background subtraction: the first frame of NUM_SAMPLES pixels loads the
// background store, and each later frame ends in one word that reports movement, the changed
// sample count and whether the background was refreshed. One pixel word is accepted every
// clock cycle while input ready is high; the result word is registered from the last item.
// Results wait in two output registers, so input ready falls only while both hold a word that
// has not been taken and the next frame's last pixel has reached the compare stage; it never
// follows output ready combinationally. The background store is one memory of
// NUM_SAMPLES seven-bit entries with one read and one write port and needs no clearing.
// Uses fmd_pkg, fmd_pixel_if, fmd_result_if, fmd_sequencer, fmd_bg_store and fmd_evaluate.
`default_nettype none

module frame_difference_motion_detector import fmd_pkg::*; #(
    parameter int NUM_SAMPLES = DEF_NUM_SAMPLES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    fmd_pixel_if.sink                  i_pixel,
    fmd_result_if.source               o_result
);

    localparam int POS_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

    t_cfg              r_cfg;
    logic              accept;
    logic              stall;
    logic              advance;
    logic [POS_W-1:0]  rd_pos;
    logic              s1_valid;
    t_item             s1_item;
    logic [POS_W-1:0]  s1_pos;
    logic [LUMA_W-1:0] bg_level;
    logic              wr_en;
    logic [LUMA_W-1:0] wr_data;
    logic              out_valid;
    t_result           result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.diff_threshold <= RST_DIFF_THRESHOLD;
            r_cfg.min_changed <= RST_MIN_CHANGED;
            r_cfg.refresh_shift <= RST_REFRESH_SHIFT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIFF_THRESHOLD: begin
                    r_cfg.diff_threshold <= i_cfg_data[THR_W-1:0];
                end
                CFG_MIN_CHANGED: begin
                    r_cfg.min_changed <= i_cfg_data[MINC_W-1:0];
                end
                CFG_REFRESH_SHIFT: begin
                    r_cfg.refresh_shift <= i_cfg_data[SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign i_pixel.ready = !stall;
    assign accept = i_pixel.valid && !stall;

    fmd_sequencer #(
        .NUM_SAMPLES(NUM_SAMPLES)
    ) u_sequencer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_pixel        (i_pixel.pixel),
        .i_refresh_shift(r_cfg.refresh_shift),
        .i_advance      (advance),
        .o_rd_pos       (rd_pos),
        .o_s1_valid     (s1_valid),
        .o_s1_item      (s1_item),
        .o_s1_pos       (s1_pos)
    );

    fmd_bg_store #(
        .NUM_SAMPLES(NUM_SAMPLES)
    ) u_bg_store (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_addr(rd_pos),
        .i_wr_en  (wr_en),
        .i_wr_addr(s1_pos),
        .i_wr_data(wr_data),
        .o_rd_data(bg_level)
    );

    fmd_evaluate u_evaluate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s1_valid (s1_valid),
        .i_s1_item  (s1_item),
        .i_bg_level (bg_level),
        .i_out_ready(o_result.ready),
        .o_stall    (stall),
        .o_advance  (advance),
        .o_wr_en    (wr_en),
        .o_wr_data  (wr_data),
        .o_out_valid(out_valid),
        .o_result   (result)
    );

    assign o_result.valid = out_valid;
    assign o_result.movement = result.movement;
    assign o_result.changed_count = result.changed_count;
    assign o_result.refreshed = result.refreshed;
    assign o_result.refresh_count = result.refresh_count;

endmodule

`default_nettype wire

### verif/frame_difference_motion_detector_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_difference_motion_detector: a table of directed frames,
// then random frames around the stored background, checked against the table or a predictor.
// Depends on fmd_pkg, fmd_pixel_if, fmd_result_if and the block's RTL.

module frame_difference_motion_detector_tb;
    import fmd_pkg::*;

    localparam int FRAME_LEN    = DEF_NUM_SAMPLES;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_LUMA     = 125;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_FRAMES = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] minc;
        logic [CFG_DATA_W-1:0] shift;
        logic [PIXEL_W-1:0]    base_px;
        logic [5:0]            alt_n;
        logic [PIXEL_W-1:0]    alt_px;
        logic                  typed;
        t_result               want;
    } t_frame_row;

    localparam t_frame_row DIRECTED_ROWS [10] = '{
        '{7'd12, 7'd4, 7'd5, 16'h0000, 6'd0, 16'h0000, 1'b0, '{1'b0, 6'd0, 1'b0, 8'd0}},
        '{7'd12, 7'd4, 7'd5, 16'hFFFF, 6'd0, 16'h0000, 1'b1, '{1'b1, 6'd48, 1'b0, 8'd0}},
        '{7'd12, 7'd4, 7'd5, 16'h0000, 6'd0, 16'h0000, 1'b1, '{1'b0, 6'd0, 1'b0, 8'd0}},
        '{7'd12, 7'd4, 7'd0, 16'hFFFF, 6'd0, 16'h0000, 1'b1, '{1'b1, 6'd48, 1'b1, 8'd2}},
        '{7'h7F, 7'd4, 7'd0, 16'h0000, 6'd0, 16'h0000, 1'b1, '{1'b0, 6'd0, 1'b1, 8'd3}},
        '{7'd124, 7'd4, 7'd0, 16'hFFFF, 6'd0, 16'h0000, 1'b1, '{1'b1, 6'd48, 1'b1, 8'd4}},
        '{7'd0, 7'h7F, 7'd1, 16'hFFFF, 6'd10, 16'hFFDF, 1'b1, '{1'b0, 6'd10, 1'b0, 8'd2}},
        '{7'd0, 7'd0, 7'h7F, 16'hFFFF, 6'd0, 16'h0000, 1'b1, '{1'b1, 6'd0, 1'b0, 8'd0}},
        '{7'd12, 7'd48, 7'd1, 16'h0000, 6'd20, 16'h7BEF, 1'b0, '{1'b0, 6'd0, 1'b0, 8'd0}},
        '{7'd3, 7'd20, 7'd1, 16'hF800, 6'd24, 16'h07E0, 1'b0, '{1'b0, 6'd0, 1'b0, 8'd0}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fmd_pixel_if  pix_if ();
    fmd_result_if res_if ();

    frame_difference_motion_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pixel     (pix_if),
        .o_result    (res_if)
    );

    logic [LUMA_W-1:0]  bg_level [FRAME_LEN];
    int                 sample_pos;
    logic [COUNT_W-1:0] tally;
    bit                 bg_loaded;
    logic [FRAME_W-1:0] frame_no;
    logic [THR_W-1:0]   thr_reg;
    logic [MINC_W-1:0]  minc_reg;
    logic [SHIFT_W-1:0] shift_reg;

    t_result pending_summaries [$];
    t_result oldest;
    int      errors = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit predict_summary(input logic [PIXEL_W-1:0] px,
                                           output t_result summary);
        int                 pos;
        int                 lum;
        int                 bg;
        int                 diff;
        bit                 last;
        bit                 refresh;
        logic [FRAME_W-1:0] mask;
        summary = '0;
        pos = (sample_pos >= FRAME_LEN) ? 0 : sample_pos;
        last = (pos + 1 >= FRAME_LEN);
        sample_pos = last ? 0 : pos + 1;
        lum = int'(px[15:11]) + int'(px[10:5]) + int'(px[4:0]);
        if (!bg_loaded) begin
            bg_level[pos] = LUMA_W'(lum);
            if (last) begin
                bg_loaded = 1'b1;
            end
            return 1'b0;
        end
        mask = FRAME_W'((32'd1 << shift_reg) - 32'd1);
        refresh = (frame_no != '0) && ((frame_no & mask) == '0);
        bg = int'(bg_level[pos]);
        diff = (lum >= bg) ? lum - bg : bg - lum;
        if (diff > int'(thr_reg) && tally < TALLY_MAX) begin
            tally++;
        end
        if (refresh) begin
            bg_level[pos] = LUMA_W'(lum);
        end
        if (!last) begin
            return 1'b0;
        end
        summary.movement      = (tally >= minc_reg);
        summary.changed_count = tally;
        summary.refreshed     = refresh;
        summary.refresh_count = RCOUNT_W'(frame_no >> shift_reg);
        tally = '0;
        frame_no++;
        return 1'b1;
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct = 75;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                recv_stall_pct = 75;
            end
            default: begin
                send_idle_pct = 36;
                recv_stall_pct = 36;
            end
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_DIFF_THRESHOLD: thr_reg = data[THR_W-1:0];
            CFG_MIN_CHANGED:    minc_reg = data[MINC_W-1:0];
            CFG_REFRESH_SHIFT:  shift_reg = data[SHIFT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] minc,
                                input logic [CFG_DATA_W-1:0] shift);
        if (thr_reg != thr[THR_W-1:0]) begin
            write_reg(CFG_DIFF_THRESHOLD, thr);
        end
        if (minc_reg != minc[MINC_W-1:0]) begin
            write_reg(CFG_MIN_CHANGED, minc);
        end
        if (shift_reg != shift[SHIFT_W-1:0]) begin
            write_reg(CFG_REFRESH_SHIFT, shift);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic push_pixel(input logic [PIXEL_W-1:0] px, input bit typed,
                              input t_result want);
        t_result summary;
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        do @(posedge i_clk); while (!pix_if.ready);
        if (predict_summary(px, summary)) begin
            pending_summaries.push_back(typed ? want : summary);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (pending_summaries.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_summaries.size() == 0) begin
                report("result word arrived with no frame summary pending");
            end else begin
                oldest = pending_summaries.pop_front();
                if (res_if.movement !== oldest.movement) begin
                    report($sformatf("movement %b, expected %b",
                                     res_if.movement, oldest.movement));
                end
                if (res_if.changed_count !== oldest.changed_count) begin
                    report($sformatf("changed_count %0d, expected %0d",
                                     res_if.changed_count, oldest.changed_count));
                end
                if (res_if.refreshed !== oldest.refreshed) begin
                    report($sformatf("refreshed %b, expected %b",
                                     res_if.refreshed, oldest.refreshed));
                end
                if (res_if.refresh_count !== oldest.refresh_count) begin
                    report($sformatf("refresh_count %0d, expected %0d",
                                     res_if.refresh_count, oldest.refresh_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("frame_difference_motion_detector verification failed");
            $finish;
        end
    end

    initial begin
        t_frame_row         row;
        int                 ph;
        int                 fr;
        int                 k;
        int                 pct;
        int                 bg;
        int                 off;
        int                 lvl;
        int                 r;
        int                 g;
        int                 rest;
        logic [PIXEL_W-1:0] px;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        res_if.ready = 1'b0;

        sample_pos = 0;
        tally = '0;
        bg_loaded = 1'b0;
        frame_no = '0;
        thr_reg = RST_DIFF_THRESHOLD;
        minc_reg = RST_MIN_CHANGED;
        shift_reg = RST_REFRESH_SHIFT;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A write to the unused index must leave every register as it was.
        write_reg(CFG_UNUSED, 7'h55);

        foreach (DIRECTED_ROWS[n]) begin
            row = DIRECTED_ROWS[n];
            set_idling(n % 4);
            apply_config(row.thr, row.minc, row.shift);
            for (k = 0; k < FRAME_LEN; k++) begin
                push_pixel((k < int'(row.alt_n)) ? row.alt_px : row.base_px,
                           row.typed, row.want);
            end
            wait_idle();
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            set_idling(ph % 4);
            apply_config((ph == 4) ? 7'd0 : (ph == 7) ? 7'h7F : 7'($urandom_range(30)),
                         (ph == 2) ? 7'd0 : (ph == 5) ? 7'd63 : 7'($urandom_range(48)),
                         (ph == 3) ? 7'd15 : 7'($urandom_range(3)));
            for (fr = 0; fr < PHASE_FRAMES; fr++) begin
                pct = $urandom_range(100);
                for (k = 0; k < FRAME_LEN; k++) begin
                    if ($urandom_range(9) == 0) begin
                        px = PIXEL_W'($urandom);
                    end else begin
                        // Aim the brightness near the threshold, inside the threshold band or anywhere in range.
                        bg = int'(bg_level[sample_pos]);
                        if ($urandom_range(99) < pct) begin
                            off = $urandom_range(1) ? int'(thr_reg) + int'($urandom_range(2)) - 1
                                                    : int'($urandom_range(MAX_LUMA));
                        end else begin
                            off = int'($urandom_range(int'(thr_reg)));
                        end
                        lvl = $urandom_range(1) ? bg + off : bg - off;
                        if (lvl < 0) begin
                            lvl = 0;
                        end
                        if (lvl > MAX_LUMA) begin
                            lvl = MAX_LUMA;
                        end
                        r = $urandom_range((lvl < 31) ? lvl : 31, (lvl > 94) ? lvl - 94 : 0);
                        rest = lvl - r;
                        g = $urandom_range((rest < 63) ? rest : 63, (rest > 31) ? rest - 31 : 0);
                        px = {r[4:0], g[5:0], 5'(rest - g)};
                    end
                    push_pixel(px, 1'b0, '0);
                end
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("frame_difference_motion_detector verification clean");
        end else begin
            $display("frame_difference_motion_detector verification failed");
        end
        $finish;
    end

endmodule
